FILE: src/b2da_pkg.sv
`default_nettype none

package b2da_pkg;

   localparam int VALUE_W    = 32;
   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = 10;
   localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
   localparam int CHAR_W     = 6;
   localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);
   localparam int BITCNT_W   = $clog2(VALUE_W);

   localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
   localparam logic [DIGIT_W-1:0] DAB_LIMIT  = DIGIT_W'(5);
   localparam logic [DIGIT_W-1:0] DAB_ADJUST = DIGIT_W'(3);

   typedef enum logic [1:0] {
      DAB_IDLE,
      DAB_SHIFT,
      DAB_HOLD
   } dab_state_type;

   typedef enum logic [1:0] {
      EMT_IDLE,
      EMT_SKIP,
      EMT_SEND
   } emt_state_type;

   // handoff of one converted number from the converter to the emitter
   typedef struct packed {
      logic             valid;
      logic [BCD_W-1:0] digits;
   } bcd_xfer_type;

endpackage

`default_nettype wire

FILE: src/b2da_dabble.sv
`default_nettype none

module b2da_dabble
   import b2da_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [VALUE_W-1:0] in_value,
   output bcd_xfer_type            xfer,
   input  wire logic               xfer_ready
);

   dab_state_type         state_ff, state_in;
   logic [VALUE_W-1:0]    bin_ff, bin_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [BITCNT_W-1:0]   count_ff, count_in;
   logic [BCD_W-1:0]      adj;

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= DAB_LIMIT) begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + DAB_ADJUST;
         end else begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DAB_IDLE: begin
            if (in_valid) state_in = DAB_SHIFT;
         end
         DAB_SHIFT: begin
            if (count_ff == BITCNT_W'(VALUE_W - 1)) state_in = DAB_HOLD;
         end
         DAB_HOLD: begin
            if (xfer_ready) state_in = DAB_IDLE;
         end
         default: state_in = DAB_IDLE;
      endcase
   end

   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      unique case (state_ff)
         DAB_IDLE: begin
            bin_in   = in_value;
            bcd_in   = '0;
            count_in = '0;
         end
         DAB_SHIFT: begin
            bcd_in   = {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
            bin_in   = {bin_ff[VALUE_W-2:0], 1'b0};
            count_in = count_ff + BITCNT_W'(1);
         end
         DAB_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      in_ready    = (state_ff == DAB_IDLE);
      xfer.valid  = (state_ff == DAB_HOLD);
      xfer.digits = bcd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DAB_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      count_ff <= count_in;
   end

endmodule

`default_nettype wire

FILE: src/b2da_emit.sv
`default_nettype none

module b2da_emit
   import b2da_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire bcd_xfer_type xfer,
   output logic              xfer_ready,
   output logic              out_valid,
   input  wire logic         out_ready,
   output logic [CHAR_W-1:0] out_char,
   output logic              out_last
);

   emt_state_type       state_ff, state_in;
   logic [BCD_W-1:0]    digits_ff, digits_in;
   logic [LEFT_W-1:0]   left_ff, left_in;
   logic [DIGIT_W-1:0]  top;
   logic                final_digit;

   assign top         = digits_ff[BCD_W-1 -: DIGIT_W];
   assign final_digit = (left_ff == LEFT_W'(1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         EMT_IDLE: begin
            if (xfer.valid) state_in = EMT_SKIP;
         end
         EMT_SKIP: begin
            if (top != '0 || final_digit) state_in = EMT_SEND;
         end
         EMT_SEND: begin
            if (out_ready && final_digit) state_in = EMT_IDLE;
         end
         default: state_in = EMT_IDLE;
      endcase
   end

   // one digit a cycle leaves the top of the shift register, except while a digit waits on out_ready
   always_comb begin
      digits_in = digits_ff;
      left_in   = left_ff;
      unique case (state_ff)
         EMT_IDLE: begin
            digits_in = xfer.digits;
            left_in   = LEFT_W'(NUM_DIGITS);
         end
         EMT_SKIP: begin
            if (top == '0 && !final_digit) begin
               digits_in = {digits_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               left_in   = left_ff - LEFT_W'(1);
            end
         end
         EMT_SEND: begin
            if (out_ready && !final_digit) begin
               digits_in = {digits_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               left_in   = left_ff - LEFT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      xfer_ready = (state_ff == EMT_IDLE);
      out_valid  = (state_ff == EMT_SEND);
      out_char   = ASCII_ZERO + CHAR_W'(top);
      out_last   = final_digit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EMT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      digits_ff <= digits_in;
      left_ff   <= left_in;
   end

endmodule

`default_nettype wire

FILE: src/binary_to_decimal_ascii.sv
// converter: shift-add-3 steps, one input bit each, then a handoff that waits for the emitter
// emitter: skips up to 9 leading zeros, then sends one digit per cycle unless the result side stalls
// the bit-serial converter sets the item rate; the emitter finishes an item sooner than the
// converter converts one, so only result-side stalls can hold back the handoff
// reset: synchronous active-high reset returns both state machines to idle
`default_nettype none

module binary_to_decimal_ascii
   import b2da_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input item
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   // result item, one per decimal digit
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [5:0] digit_char, [7:6] zero
   output logic             rsp_tlast    // last digit of the run
);

   bcd_xfer_type      xfer;
   logic              xfer_ready;
   logic [CHAR_W-1:0] char;

   // bit-serial binary to bcd conversion, one item at a time
   b2da_dabble u_dabble (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_value   (req_tdata),
      .xfer       (xfer),
      .xfer_ready (xfer_ready)
   );

   // digit shift register: drops leading zeros, sends msd first
   // the converter takes the next item while this one is still sending
   b2da_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .xfer       (xfer),
      .xfer_ready (xfer_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_char   (char),
      .out_last   (rsp_tlast)
   );

   // pad the character to a whole byte
   assign rsp_tdata = {{(8 - CHAR_W){1'b0}}, char};

endmodule

`default_nettype wire

FILE: tb/sv/tb_binary_to_decimal_ascii.sv
`default_nettype none

module tb_binary_to_decimal_ascii;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                CHAR_W        = b2da_pkg::CHAR_W;
   localparam logic [CHAR_W-1:0] CHAR_ZERO     = CHAR_W'(48);
   localparam int                MAX_DIGITS    = 10;
   // the first digit follows the conversion of the item and up to 9 skipped zeros
   localparam int                SETTLE_CYCLES = 80;
   localparam int unsigned       CYCLE_LIMIT   = 400000;

   // one expected digit of the decimal text
   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
   } digit_item_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;     // [31:0] value
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;     // [5:0] digit_char, [7:6] zero
   logic        rsp_tlast;     // last digit of the run

   digit_item_type expected_digits[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   // when set, neither side idles, so items and digits go back to back
   bit          pace_quiet = 1'b0;

   binary_to_decimal_ascii DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 8 ns clock, low half first
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // idle cycles before the next item or digit
   function automatic int draw_wait();
      if (pace_quiet) begin
         return 0;
      end
      return int'($urandom_range(0, 5));
   endfunction

   // decimal text of one value, most significant digit first, no leading zeros
   function automatic void queue_decimal_text(input logic [31:0] value);
      logic [31:0]    rest;
      logic [3:0]     lsd_first[MAX_DIGITS];
      int             count;
      digit_item_type item;
      rest  = value;
      count = 0;
      do begin
         lsd_first[count] = 4'(rest % 32'd10);
         rest             = rest / 32'd10;
         count++;
      end while (rest != 32'd0 && count < MAX_DIGITS);
      for (int k = count - 1; k >= 0; k--) begin
         item.digit_char = CHAR_ZERO + CHAR_W'(lsd_first[k]);
         item.last       = (k == 0);
         expected_digits.push_back(item);
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   // digits are checked and items predicted at the same edge, so the
   // store never races between two processes
   always @(posedge clock) begin : digit_check
      digit_item_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_digits.size() == 0) begin
               report_mismatch($sformatf("digit 0x%02h last %0b with none expected",
                                         rsp_tdata, rsp_tlast));
            end else begin
               want = expected_digits.pop_front();
               if (rsp_tdata[CHAR_W-1:0] !== want.digit_char) begin
                  report_mismatch($sformatf("digit_char got %0d expected %0d",
                                            rsp_tdata[CHAR_W-1:0], want.digit_char));
               end
               if (rsp_tdata[7:CHAR_W] !== '0) begin
                  report_mismatch($sformatf("padding bits got %b", rsp_tdata[7:CHAR_W]));
               end
               if (rsp_tlast !== want.last) begin
                  report_mismatch($sformatf("last got %b expected %b on digit %0d",
                                            rsp_tlast, want.last, want.digit_char));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            queue_decimal_text(req_tdata);
         end
      end
   end

   // digit sink: a fresh stall before every digit
   initial begin : digit_sink
      int stall;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = draw_wait();
         @(negedge clock);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // offers one value and returns at the edge that takes it;
   // valid stays high until the next falling edge
   task automatic send_value(input logic [31:0] value);
      int gap;
      gap = draw_wait();
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering and hold off until every digit is back
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_digits.size() != 0) @(posedge clock);
   endtask

   function automatic longint unsigned pow10(input int n);
      longint unsigned p;
      p = 1;
      repeat (n) p = p * 10;
      return p;
   endfunction

   // zero, and both sides of every change in digit count
   task automatic test_digit_boundaries();
      logic [31:0] p;
      p = 32'd1;
      send_value(32'd0);
      send_value(32'd1);
      for (int k = 1; k <= 9; k++) begin
         p = p * 32'd10;
         send_value(p - 32'd1);
         send_value(p);
      end
      drain_results();
   endtask

   // full scale and its neighbours, the top bit, alternating bit patterns and 1234567890
   task automatic test_bit_extremes();
      send_value(32'hFFFF_FFFF);
      send_value(32'hFFFF_FFFE);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      send_value(32'hAAAA_AAAA);
      send_value(32'h5555_5555);
      send_value(32'd1234567890);
      drain_results();
   endtask

   // digit count drawn first so short runs are as common as long ones
   task automatic test_random_lengths(input int count);
      int              n;
      longint unsigned lo;
      longint unsigned hi;
      for (int i = 0; i < count; i++) begin
         // a back-to-back stretch at the start
         pace_quiet = (i < 30);
         n  = int'($urandom_range(1, 10));
         lo = (n == 1) ? 0 : pow10(n - 1);
         hi = (n == 10) ? 64'hFFFF_FFFF : pow10(n) - 1;
         send_value($urandom_range(32'(hi), 32'(lo)));
      end
      pace_quiet = 1'b0;
      drain_results();
   endtask

   // uniform over the whole word, mostly ten-digit values
   task automatic test_random_full_width(input int count);
      for (int i = 0; i < count; i++) begin
         send_value($urandom());
      end
      drain_results();
   endtask

   // values within three of a power of ten, and full scale down to five below it
   task automatic test_random_near_boundaries(input int count);
      longint signed v;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            v = 64'hFFFF_FFFF - $urandom_range(0, 5);
         end else begin
            v = longint'(pow10(int'($urandom_range(1, 9)))) + int'($urandom_range(0, 6)) - 3;
         end
         send_value(32'(v));
      end
      drain_results();
   endtask

   initial begin : stimulus
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_digit_boundaries();
      test_bit_extremes();
      test_random_lengths(100);
      test_random_full_width(100);
      test_random_near_boundaries(100);

      // all digits are back; look for strays a while longer
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("binary_to_decimal_ascii verification clean");
      end else begin
         $display("binary_to_decimal_ascii verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("binary_to_decimal_ascii verification failed");
      $finish;
   end

endmodule

`default_nettype wire
